// File: rtl/bmh_pkg.sv
// Shared types and codes of the binary min-heap priority queue.
package bmh_pkg;

  localparam int PRI_W = 16;
  localparam int PAY_W = 32;
  localparam int ENT_W = PRI_W + PAY_W;

  // Operation codes carried on the input side band
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [PAY_W-1:0] pay;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PU_RD,
    S_PU_CMP,
    S_PO_LAST,
    S_PO_ENT,
    S_SD_RDL,
    S_SD_RDR,
    S_SD_CMPR,
    S_FIN
  } state_t;

endpackage

// File: rtl/binary_min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue: sequencer, comparator and heap RAM.
//
// Usage:
//   The slave channel takes one request per transfer. s_tuser carries the operation
//   (push or pop); s_tdata carries the priority and the payload of a push.
//   The master channel returns exactly one result per request: the status
//   goes out on m_tuser (ok, pop on empty, push on full), m_tdata carries the
//   popped payload and priority (zero on a push or a failed request) and the
//   number of entries held after the operation.
//   One request is worked at a time; s_tready is high only while the sequencer
//   is idle. A push rises level by level, reading the parent and then comparing;
//   a pop takes the last entry as the sinking entry at the root and sinks it
//   level by level, reading the left and the right child and then comparing;
//   a rejected request goes straight to its result. The result shows
//   on the master side at the edge where s_tready returns. The heap RAM
//   returns its read data registered, so each level reads before it compares.
//   The result waits in an output register while the receiver stalls; the
//   sequencer holds its finished result until that register frees.
//   Reset empties the heap and drops any pending result; the RAM is not cleared.
module binary_min_heap_priority_queue
  import bmh_pkg::*;
#(
  parameter int  CAPACITY = 64,
  localparam int IW       = $clog2(CAPACITY + 1),  // slot index and count width
  localparam int M_W      = ((ENT_W + IW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // priority_req[15:0], payload[47:16]
  input  logic                  s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_W-1:0]        m_tdata,   // out_payload, out_priority, count, zero pad
  output logic [1:0]            m_tuser    // status
);

  localparam int AW  = $clog2(CAPACITY);      // RAM address width
  localparam logic [IW-1:0] CAP = IW'(CAPACITY);
  localparam logic [IW-1:0] ONE = IW'(1);

  state_t state, state_next;

  logic [IW-1:0] count;
  logic [IW-1:0] idx;
  entry_t        ent;      // entry being placed: pushed item or former last entry
  entry_t        cand;     // best of sinking entry and left child
  logic          take_left;
  logic [1:0]    r_status;
  entry_t        r_out;

  // Heap RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rd;

  // Shared comparator
  logic [PRI_W-1:0] cmp_x, cmp_y;
  logic             cmp_lt;

  // Child indices of the current slot
  logic [IW:0] jl, jr;
  logic        has_left, has_right;
  logic        out_free, accept;

  function automatic logic [AW-1:0] slot_addr(input logic [IW:0] slot);
    logic [IW:0] a;
    a = slot - (IW+1)'(1);
    return a[AW-1:0];
  endfunction

  assign jl        = {idx, 1'b0};
  assign jr        = {idx, 1'b1};
  assign has_left  = jl <= {1'b0, count};
  assign has_right = jr <= {1'b0, count};
  assign out_free  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  bmh_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd)
  );

  // Compare operands follow the step: parent versus pushed entry, then the left
  // child versus the sinking entry and the right child versus the better of the two.
  always_comb begin
    case (state)
      S_PU_CMP: begin
        cmp_x = ent.pri;
        cmp_y = rd.pri;
      end
      S_SD_RDR: begin
        cmp_x = rd.pri;
        cmp_y = ent.pri;
      end
      S_SD_CMPR: begin
        cmp_x = rd.pri;
        cmp_y = cand.pri;
      end
      default: begin
        cmp_x = rd.pri;
        cmp_y = ent.pri;
      end
    endcase
  end

  assign cmp_lt = cmp_x < cmp_y;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_PUSH) begin
            state_next = (count == CAP) ? S_FIN : S_PU_RD;
          end else begin
            state_next = (count == '0) ? S_FIN : S_PO_LAST;
          end
        end
      end
      S_PU_RD:   state_next = (idx == ONE) ? S_FIN : S_PU_CMP;
      S_PU_CMP:  state_next = cmp_lt ? S_PU_RD : S_FIN;
      S_PO_LAST: state_next = S_PO_ENT;
      S_PO_ENT:  state_next = (count == '0) ? S_FIN : S_SD_RDL;
      S_SD_RDL:  state_next = has_left ? S_SD_RDR : S_FIN;
      S_SD_RDR: begin
        if (has_right) begin
          state_next = S_SD_CMPR;
        end else begin
          state_next = cmp_lt ? S_SD_RDL : S_FIN;
        end
      end
      S_SD_CMPR: state_next = (cmp_lt || take_left) ? S_SD_RDL : S_FIN;
      S_FIN:     state_next = out_free ? S_IDLE : S_FIN;
      default:   state_next = S_IDLE;
    endcase
  end

  // RAM controls and handshake
  always_comb begin
    s_tready = (state == S_IDLE);
    we       = 1'b0;
    waddr    = slot_addr({1'b0, idx});
    wdata    = ent;
    raddr    = slot_addr((IW+1)'(1));   // root, read ahead while idle
    case (state)
      S_PU_RD: begin
        we    = (idx == ONE);
        raddr = slot_addr({2'b00, idx[IW-1:1]});
      end
      S_PU_CMP: begin
        we    = 1'b1;
        wdata = cmp_lt ? rd : ent;
      end
      S_PO_LAST: begin
        raddr = slot_addr({1'b0, count});
      end
      S_SD_RDL: begin
        we    = !has_left;
        raddr = slot_addr(jl);
      end
      S_SD_RDR: begin
        raddr = slot_addr(jr);
        we    = !has_right;
        wdata = cmp_lt ? rd : ent;
      end
      S_SD_CMPR: begin
        we = 1'b1;
        if (cmp_lt) begin
          wdata = rd;
        end else if (take_left) begin
          wdata = cand;
        end else begin
          wdata = ent;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && accept && s_tuser == OP_PUSH && count != CAP) begin
        count <= count + ONE;
      end
      if (state == S_PO_LAST) begin
        count <= count - ONE;
      end
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ent.pri   <= s_tdata[PRI_W-1:0];
        ent.pay   <= s_tdata[ENT_W-1:PRI_W];
        idx       <= count + ONE;
        r_out     <= '0;
        if (s_tuser == OP_PUSH) begin
          r_status <= (count == CAP) ? ST_FULL : ST_OK;
        end else begin
          r_status <= (count == '0) ? ST_EMPTY : ST_OK;
        end
      end
      S_PU_CMP: begin
        if (cmp_lt) begin
          idx <= {1'b0, idx[IW-1:1]};
        end
      end
      S_PO_LAST: begin
        r_out <= rd;
      end
      S_PO_ENT: begin
        ent <= rd;
        idx <= ONE;
      end
      S_SD_RDR: begin
        cand      <= cmp_lt ? rd : ent;
        take_left <= cmp_lt;
        if (!has_right && cmp_lt) begin
          idx <= jl[IW-1:0];
        end
      end
      S_SD_CMPR: begin
        if (cmp_lt) begin
          idx <= jr[IW-1:0];
        end else if (take_left) begin
          idx <= jl[IW-1:0];
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_tuser <= r_status;
          m_tdata <= M_W'({count, r_out.pri, r_out.pay});
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

// File: rtl/bmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bmh_chk.sv
// Port-level checker of the binary min-heap priority queue, bound to the top level.
module bmh_chk
  import bmh_pkg::*;
#(
  parameter int  CAPACITY = 64,
  localparam int IW       = $clog2(CAPACITY + 1),
  localparam int M_W      = ((ENT_W + IW + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_W-1:0]        m_tdata,
  input logic [1:0]            m_tuser
);

  // One request in flight: a transfer closes the slave side next cycle.
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is being worked");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Failed requests carry no entry.
  a_zero_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[ENT_W-1:0] == '0)
    else $error("failed request returned entry data");

  // Status is a known code and the count never exceeds capacity.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL) &&
                 (m_tdata[ENT_W+IW-1:ENT_W] <= IW'(CAPACITY)))
    else $error("bad status code or count");

endmodule

bind binary_min_heap_priority_queue bmh_chk #(
  .CAPACITY(CAPACITY)
) u_bmh_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
